FILE: sv/cfpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfpp_pkg
// Shared types, codes and helpers of the class file constant pool parser.
// ----------------------------------------------------------------------------
package cfpp_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 152;
    localparam int M_TUSER_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [31:0] MAGIC_WORD      = 32'hCAFE_BABE;
    localparam logic [15:0] MAJOR_BASE      = 16'd45;
    localparam logic [15:0] MAJOR_STRICT    = 16'd46;
    localparam logic [15:0] MAX_MAJOR_RESET = 16'd52;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_COUNT   = 3'd2,
        PH_TAG     = 3'd3,
        PH_BODY    = 3'd4,
        PH_TEXT    = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } phase_t;

    localparam logic [2:0] KIND_ENTRY       = 3'd0;
    localparam logic [2:0] KIND_UTF8        = 3'd1;
    localparam logic [2:0] KIND_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] KIND_BAD_VERSION = 3'd3;
    localparam logic [2:0] KIND_BAD_TAG     = 3'd4;
    localparam logic [2:0] KIND_EMPTY_POOL  = 3'd5;

    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_INTEGER       = 8'd3;
    localparam logic [7:0] TAG_FLOAT         = 8'd4;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_STRING        = 8'd8;
    localparam logic [7:0] TAG_FIELD_REF     = 8'd9;
    localparam logic [7:0] TAG_METHOD_REF    = 8'd10;
    localparam logic [7:0] TAG_IFACE_REF     = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;
    localparam logic [7:0] TAG_METHOD_HANDLE = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE   = 8'd16;
    localparam logic [7:0] TAG_INVOKE_DYN    = 8'd18;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] entry_index;
        logic [7:0]  entry_tag;
        logic [15:0] first_index;
        logic [15:0] second_index;
        logic [63:0] constant_value;
        logic [7:0]  text_byte;
        logic [15:0] text_offset;
        logic        entry_end;
        logic        pool_done;
    } result_t;

    function automatic logic [3:0] body_length(input logic [7:0] tag);
        logic [3:0] len;
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: len = 4'd2;
            TAG_METHOD_HANDLE: len = 4'd3;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELD_REF, TAG_METHOD_REF, TAG_IFACE_REF,
            TAG_NAME_AND_TYPE, TAG_INVOKE_DYN: len = 4'd4;
            TAG_LONG, TAG_DOUBLE: len = 4'd8;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

FILE: sv/cfpp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfpp_core
// Parse state and per-byte decode: magic, version, pool count, entries.
// ----------------------------------------------------------------------------
module cfpp_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire cfpp_pkg::in_word_t in_word,
    input  wire logic [15:0]       max_major,
    output logic                   res_valid,
    output cfpp_pkg::result_t      res
);

    cfpp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] slot_reg, slot_next;
    logic [15:0] pool_reg, pool_next;
    logic [7:0]  tag_reg, tag_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] tpos_reg, tpos_next;
    logic [15:0] minor_reg, minor_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cfpp_pkg::PH_MAGIC;
            cnt_reg   <= '0;
            slot_reg  <= 16'd1;
            pool_reg  <= '0;
            tag_reg   <= '0;
            acc_reg   <= '0;
            tlen_reg  <= '0;
            tpos_reg  <= '0;
            minor_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            slot_reg  <= slot_next;
            pool_reg  <= pool_next;
            tag_reg   <= tag_next;
            acc_reg   <= acc_next;
            tlen_reg  <= tlen_next;
            tpos_reg  <= tpos_next;
            minor_reg <= minor_next;
        end
    end

    always_comb begin
        cfpp_pkg::phase_t c_phase;
        logic [3:0]  c_cnt;
        logic [15:0] c_slot;
        logic [15:0] c_pool;
        logic [7:0]  c_tag;
        logic [63:0] c_acc;
        logic [15:0] c_tlen;
        logic [15:0] c_tpos;
        logic [15:0] c_minor;
        logic [7:0]  b;
        logic [3:0]  cnt_inc;
        logic [31:0] acc32;
        logic [63:0] acc64;
        logic [15:0] pool_sh;
        logic [15:0] major;
        logic [16:0] fin_slot;
        logic        fin_last;
        logic        finish;

        b = in_word.byte_value;
        if (in_word.first_byte) begin
            c_phase = cfpp_pkg::PH_MAGIC;
            c_cnt   = '0;
            c_slot  = 16'd1;
            c_pool  = '0;
            c_tag   = '0;
            c_acc   = '0;
            c_tlen  = '0;
            c_tpos  = '0;
            c_minor = '0;
        end else begin
            c_phase = phase_reg;
            c_cnt   = cnt_reg;
            c_slot  = slot_reg;
            c_pool  = pool_reg;
            c_tag   = tag_reg;
            c_acc   = acc_reg;
            c_tlen  = tlen_reg;
            c_tpos  = tpos_reg;
            c_minor = minor_reg;
        end

        cnt_inc  = c_cnt + 4'd1;
        acc32    = {c_acc[23:0], b};
        acc64    = {c_acc[55:0], b};
        pool_sh  = {c_pool[7:0], b};
        major    = acc32[15:0];
        fin_slot = {1'b0, c_slot} + ((c_tag inside {cfpp_pkg::TAG_LONG, cfpp_pkg::TAG_DOUBLE})
                   ? 17'd2 : 17'd1);
        fin_last = fin_slot >= {1'b0, c_pool};
        finish   = 1'b0;

        phase_next = c_phase;
        cnt_next   = c_cnt;
        slot_next  = c_slot;
        pool_next  = c_pool;
        tag_next   = c_tag;
        acc_next   = c_acc;
        tlen_next  = c_tlen;
        tpos_next  = c_tpos;
        minor_next = c_minor;
        res_valid  = 1'b0;
        res        = '0;

        case (c_phase)
            cfpp_pkg::PH_MAGIC: begin
                acc_next = {32'd0, acc32};
                cnt_next = cnt_inc;
                if (cnt_inc == 4'd4) begin
                    cnt_next = '0;
                    if (acc32 != cfpp_pkg::MAGIC_WORD) begin
                        res_valid          = 1'b1;
                        res.result_kind    = cfpp_pkg::KIND_BAD_MAGIC;
                        res.constant_value = {32'd0, acc32};
                        phase_next         = cfpp_pkg::PH_ERROR;
                    end else begin
                        acc_next   = '0;
                        phase_next = cfpp_pkg::PH_VERSION;
                    end
                end
            end
            cfpp_pkg::PH_VERSION: begin
                acc_next = {32'd0, acc32};
                cnt_next = cnt_inc;
                if (cnt_inc == 4'd2) begin
                    minor_next = acc32[15:0];
                end
                if (cnt_inc == 4'd4) begin
                    cnt_next = '0;
                    if (major == cfpp_pkg::MAJOR_BASE ||
                        (major >= cfpp_pkg::MAJOR_STRICT && major <= max_major &&
                         c_minor == 16'd0)) begin
                        acc_next   = '0;
                        phase_next = cfpp_pkg::PH_COUNT;
                    end else begin
                        res_valid          = 1'b1;
                        res.result_kind    = cfpp_pkg::KIND_BAD_VERSION;
                        res.constant_value = {32'd0, acc32};
                        phase_next         = cfpp_pkg::PH_ERROR;
                    end
                end
            end
            cfpp_pkg::PH_COUNT: begin
                pool_next = pool_sh;
                cnt_next  = cnt_inc;
                if (cnt_inc == 4'd2) begin
                    cnt_next = '0;
                    if (pool_sh <= 16'd1) begin
                        res_valid       = 1'b1;
                        res.result_kind = cfpp_pkg::KIND_EMPTY_POOL;
                        res.pool_done   = 1'b1;
                        phase_next      = cfpp_pkg::PH_DONE;
                    end else begin
                        slot_next  = 16'd1;
                        phase_next = cfpp_pkg::PH_TAG;
                    end
                end
            end
            cfpp_pkg::PH_TAG: begin
                tag_next = b;
                if (cfpp_pkg::body_length(b) == 4'd0) begin
                    res_valid       = 1'b1;
                    res.result_kind = cfpp_pkg::KIND_BAD_TAG;
                    res.entry_index = c_slot;
                    res.entry_tag   = b;
                    phase_next      = cfpp_pkg::PH_ERROR;
                end else begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = cfpp_pkg::PH_BODY;
                end
            end
            cfpp_pkg::PH_BODY: begin
                acc_next = acc64;
                cnt_next = cnt_inc;
                if (cnt_inc >= cfpp_pkg::body_length(c_tag)) begin
                    cnt_next        = '0;
                    res.entry_index = c_slot;
                    res.entry_tag   = c_tag;
                    res.result_kind = cfpp_pkg::KIND_ENTRY;
                    finish          = 1'b1;
                    if (c_tag == cfpp_pkg::TAG_UTF8) begin
                        tlen_next = acc64[15:0];
                        tpos_next = '0;
                        if (acc64[15:0] != 16'd0) begin
                            finish     = 1'b0;
                            phase_next = cfpp_pkg::PH_TEXT;
                        end
                    end else if (c_tag inside {cfpp_pkg::TAG_INTEGER, cfpp_pkg::TAG_FLOAT,
                                               cfpp_pkg::TAG_LONG, cfpp_pkg::TAG_DOUBLE}) begin
                        res.constant_value = acc64;
                    end else if (c_tag inside {cfpp_pkg::TAG_CLASS,
                                               cfpp_pkg::TAG_STRING}) begin
                        res.first_index = acc64[15:0];
                    end else if (c_tag == cfpp_pkg::TAG_METHOD_TYPE) begin
                        res.second_index = acc64[15:0];
                    end else begin
                        res.first_index  = (c_tag == cfpp_pkg::TAG_METHOD_HANDLE)
                                           ? {8'd0, acc64[23:16]} : acc64[31:16];
                        res.second_index = acc64[15:0];
                    end
                    res_valid = finish;
                end
            end
            cfpp_pkg::PH_TEXT: begin
                res_valid       = 1'b1;
                res.result_kind = cfpp_pkg::KIND_UTF8;
                res.entry_index = c_slot;
                res.entry_tag   = c_tag;
                res.text_byte   = b;
                res.text_offset = c_tpos;
                tpos_next       = c_tpos + 16'd1;
                finish          = (c_tpos + 16'd1) == c_tlen;
            end
            default: begin
            end
        endcase

        if (finish) begin
            res.entry_end = 1'b1;
            slot_next     = fin_slot[15:0];
            if (fin_last) begin
                res.pool_done = 1'b1;
                phase_next    = cfpp_pkg::PH_DONE;
            end else begin
                phase_next = cfpp_pkg::PH_TAG;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/class_file_constant_pool_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// class_file_constant_pool_parser
// Streams a class file byte by byte and reports constant pool entries.
//
// s_ channel: one class file byte per word; s_tuser marks the first byte of a
// file and restarts the parse. m_ channel: at most one result word per byte,
// an entry, a UTF-8 content byte, an empty pool or an error; m_tlast marks
// the pool end. cfg_ channel: writes the highest accepted major version;
// the user must write it only when idle; the block does not enforce this;
// cfg_ready is always high. Throughput is one byte per cycle while the output
// is not stalled: a byte is registered, decoded in one pass against the parse
// state, and its result lands in the output register on its way to m_tvalid.
// While m_tready is low the result holds and at most one more byte is taken
// into the input register; the upstream then stalls, nothing is dropped.
// Reset clears the valid flags of both registers and the parse state and sets
// the version limit to 52; bytes are accepted as soon as reset is released.
// After an error or the pool end further bytes give no result until restart.
// ----------------------------------------------------------------------------
module class_file_constant_pool_parser (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [cfpp_pkg::S_TDATA_W-1:0]   s_tdata,  // byte_value
    input  wire logic                             s_tuser,  // first_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // entry_index, entry_tag, first_index, second_index, constant_value,
    // text_byte, text_offset, entry_end, zero fill
    output logic [cfpp_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [cfpp_pkg::M_TUSER_W-1:0]        m_tuser,  // result_kind
    output logic                                  m_tlast,  // pool_done
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cfpp_pkg::CFG_W-1:0]       cfg_data  // max_major_version
);

    logic               in_valid_reg, in_valid_next;
    cfpp_pkg::in_word_t in_word_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    cfpp_pkg::result_t  res_reg;
    logic [15:0]        max_major_reg;
    logic               out_free;
    logic               advance;
    logic               res_valid;
    cfpp_pkg::result_t  res;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = res_valid;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            max_major_reg <= cfpp_pkg::MAX_MAJOR_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                max_major_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_word_reg.byte_value <= s_tdata;
            in_word_reg.first_byte <= s_tuser;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    cfpp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .in_word   (in_word_reg),
        .max_major (max_major_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.result_kind;
    assign m_tlast  = res_reg.pool_done;
    assign m_tdata  = {7'd0, res_reg.entry_end, res_reg.text_offset, res_reg.text_byte,
                       res_reg.constant_value, res_reg.second_index, res_reg.first_index,
                       res_reg.entry_tag, res_reg.entry_index};

endmodule
`default_nettype wire

FILE: sv/cfpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfpp_checker
// Port-level checks on the result stream of the constant pool parser.
// ----------------------------------------------------------------------------
module cfpp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cfpp_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [cfpp_pkg::M_TUSER_W-1:0] m_tuser,
    input wire logic                          m_tlast
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result word changed");

    // pool end only on an entry end or an empty pool
    a_pool_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[144] || m_tuser == cfpp_pkg::KIND_EMPTY_POOL)
        else $error("pool end without entry end");

    // text bytes belong to utf8 entries
    a_text_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == cfpp_pkg::KIND_UTF8 |-> m_tdata[23:16] == cfpp_pkg::TAG_UTF8)
        else $error("text byte outside utf8 entry");

endmodule

bind class_file_constant_pool_parser cfpp_checker u_cfpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
